// ----- hdl/hst_pkg.sv -----
// hst_pkg: shared constants, derived widths and the histogram request type
// for the histogram split-threshold block. No dependencies.
`timescale 1ns / 1ps

package hst_pkg;

    // Block limits
    localparam int MAX_COVERAGE = 255;
    localparam int MAX_CELLS    = 4096;

    // Port field widths
    localparam int COV_W = 8;
    localparam int THR_W = 9;

    // Histogram geometry
    localparam int HIST_DEPTH = MAX_COVERAGE + 1;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(MAX_CELLS + 1);

    // Search datapath widths
    localparam int SUM_W  = $clog2(MAX_CELLS * MAX_COVERAGE + 1);
    localparam int AB_W   = SUM_W + CNT_W;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int DSQ_W  = 2 * AB_W;
    localparam int PROD_W = DSQ_W + DEN_W;
    localparam int MB_W   = (AB_W > DEN_W) ? AB_W : DEN_W;

    // Threshold code for "no split beats one class"
    localparam logic signed [THR_W-1:0] THR_NONE = -9'sd1;

    // Histogram port request
    typedef struct packed {
        logic               load;   // count one cell at level
        logic               read;   // fetch the count at level
        logic               clear;  // drop every stored count
        logic [HIST_AW-1:0] level;
    } hst_hist_req_t;

endpackage

// ----- hdl/hst_hist.sv -----
// hst_hist: level histogram memory with a one-beat-per-cycle increment
// pipeline, a read port for the split search and valid bits for clearing.
// Depends on hst_pkg.
`timescale 1ns / 1ps

module hst_hist
    import hst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hst_hist_req_t       req,
    output logic [CNT_W-1:0]    count
);

    logic [CNT_W-1:0]      mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    logic [CNT_W-1:0]      rd_data_reg;
    logic [CNT_W-1:0]      fwd_reg;
    logic                  rd_vld_reg;
    logic                  hit_reg;
    logic                  upd_reg;
    logic [HIST_AW-1:0]    upd_addr_reg;
    logic [CNT_W-1:0]      upd_value;

    // Entry not yet written this frame reads as zero; back-to-back hits forward
    assign count     = hit_reg ? fwd_reg : (rd_vld_reg ? rd_data_reg : '0);
    assign upd_value = count + CNT_W'(1);

    // Storage: write of the incremented count, registered read
    always_ff @(posedge clk)
    begin
        if (upd_reg)
        begin
            mem[upd_addr_reg] <= upd_value;
        end
        if (req.load || req.read)
        begin
            rd_data_reg <= mem[req.level];
        end
    end

    // Payload of the increment stage
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            upd_addr_reg <= req.level;
            fwd_reg      <= upd_value;
        end
    end

    // Control: valid bits, pending update, forward flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            upd_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            upd_reg <= req.load;
            if (req.clear)
            begin
                vld_reg <= '0;
            end
            else if (upd_reg)
            begin
                vld_reg[upd_addr_reg] <= 1'b1;
            end
            if (req.load || req.read)
            begin
                rd_vld_reg <= vld_reg[req.level];
                // same level as the update landing this edge: memory read is stale
                hit_reg    <= req.load && upd_reg && (req.level == upd_addr_reg);
            end
        end
    end

endmodule

// ----- hdl/hst_mul.sv -----
// hst_mul: shared shift-and-add multiplier, one multiplier bit per cycle,
// finishing as soon as the remaining multiplier bits are zero.
// Depends on hst_pkg.
`timescale 1ns / 1ps

module hst_mul
    import hst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   mcand,
    input  logic [MB_W-1:0]     mplier,
    output logic                done,
    output logic [PROD_W-1:0]   product
);

    logic              busy_reg;
    logic [PROD_W-1:0] mc_reg;
    logic [MB_W-1:0]   mp_reg;
    logic [PROD_W-1:0] acc_reg;

    assign done    = busy_reg && (mp_reg == '0);
    assign product = acc_reg;

    // Busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath: one conditional add and shift per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_reg  <= mcand;
            mp_reg  <= mplier;
            acc_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (mp_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
    end

endmodule

// ----- hdl/histogram_split_threshold.sv -----
// Sequence: after the last-cell beat, a drain state, then per level a histogram read; an empty level
// is skipped, an occupied one runs up to seven shift-and-add multiplies on the shared multiplier,
// one bit per cycle; the threshold beat is valid in the cycle after the search.
// Throughput: one cell beat per cycle while loading; one frame at a time, a new frame is taken
// once the threshold beat is delivered.
// Reset (rst_n, async, active low) returns to loading with an empty histogram at once.
`timescale 1ns / 1ps

module histogram_split_threshold
    import hst_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COV_W-1:0]        coverage_value,
    input  logic                    last_cell,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [THR_W-1:0] threshold
);

    // Sequencer states
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_HIST  = 4'd3;
    localparam logic [3:0] ST_HMUL  = 4'd4;
    localparam logic [3:0] ST_A     = 4'd5;
    localparam logic [3:0] ST_B     = 4'd6;
    localparam logic [3:0] ST_DSQ   = 4'd7;
    localparam logic [3:0] ST_DEN   = 4'd8;
    localparam logic [3:0] ST_LEFT  = 4'd9;
    localparam logic [3:0] ST_RIGHT = 4'd10;
    localparam logic [3:0] ST_NEXT  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cell_cnt_reg, cell_cnt_next;
    logic [SUM_W-1:0]         s_total_reg, s_total_next;
    logic [HIST_AW-1:0]       t_reg, t_next;
    logic [CNT_W-1:0]         n_low_reg, n_low_next;
    logic [SUM_W-1:0]         s_low_reg, s_low_next;
    logic [AB_W-1:0]          a_reg, a_next;
    logic [DSQ_W-1:0]         dsq_reg, dsq_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [PROD_W-1:0]        left_reg, left_next;
    logic [DSQ_W-1:0]         best_dsq_reg, best_dsq_next;
    logic [DEN_W-1:0]         best_den_reg, best_den_next;
    logic signed [THR_W-1:0]  best_t_reg, best_t_next;

    logic [HIST_AW-1:0]       level_sat;
    logic [CNT_W-1:0]         n_high;
    logic [SUM_W-1:0]         s_high;
    logic [SUM_W-1:0]         s_low_sum;
    logic [AB_W-1:0]          b_val;
    logic [AB_W-1:0]          d_val;

    hst_hist_req_t            hist_req;
    logic [CNT_W-1:0]         hist_count;
    logic                     mul_start;
    logic [PROD_W-1:0]        mul_mcand;
    logic [MB_W-1:0]          mul_mplier;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_product;

    hst_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hist_req),
        .count (hist_count)
    );

    hst_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign threshold = best_t_reg;

    // Saturate the level and form class totals
    assign level_sat = (coverage_value > COV_W'(MAX_COVERAGE)) ? HIST_AW'(MAX_COVERAGE)
                                                               : HIST_AW'(coverage_value);
    assign n_high    = cell_cnt_reg - n_low_reg;
    assign s_high    = s_total_reg - s_low_reg;
    assign s_low_sum = s_low_reg + SUM_W'(mul_product);
    assign b_val     = AB_W'(mul_product);
    assign d_val     = (a_reg > b_val) ? (a_reg - b_val) : (b_val - a_reg);

    // Sequencer and operand selection for the shared multiplier
    always_comb
    begin
        state_next    = state_reg;
        cell_cnt_next = cell_cnt_reg;
        s_total_next  = s_total_reg;
        t_next        = t_reg;
        n_low_next    = n_low_reg;
        s_low_next    = s_low_reg;
        a_next        = a_reg;
        dsq_next      = dsq_reg;
        den_next      = den_reg;
        left_next     = left_reg;
        best_dsq_next = best_dsq_reg;
        best_den_next = best_den_reg;
        best_t_next   = best_t_reg;
        hist_req      = '0;
        mul_start     = 1'b0;
        mul_mcand     = '0;
        mul_mplier    = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    // cells past the frame cap are dropped, last mark still counts
                    if (cell_cnt_reg < CNT_W'(MAX_CELLS))
                    begin
                        hist_req.load  = 1'b1;
                        hist_req.level = level_sat;
                        cell_cnt_next  = cell_cnt_reg + CNT_W'(1);
                        s_total_next   = s_total_reg + SUM_W'(level_sat);
                    end
                    if (last_cell)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                // last increment lands this cycle; start from one-class error
                t_next        = '0;
                n_low_next    = '0;
                s_low_next    = '0;
                best_dsq_next = '0;
                best_den_next = DEN_W'(1);
                best_t_next   = THR_NONE;
                state_next    = ST_READ;
            end

            ST_READ:
            begin
                hist_req.read  = 1'b1;
                hist_req.level = t_reg;
                state_next     = ST_HIST;
            end

            ST_HIST:
            begin
                // empty level repeats the previous split, which cannot win
                if (hist_count == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    n_low_next = n_low_reg + hist_count;
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(hist_count);
                    mul_mplier = MB_W'(t_reg);
                    state_next = ST_HMUL;
                end
            end

            ST_HMUL:
            begin
                if (mul_done)
                begin
                    s_low_next = s_low_sum;
                    if (n_low_reg == '0 || n_high == '0)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_mcand  = PROD_W'(s_low_sum);
                        mul_mplier = MB_W'(n_high);
                        state_next = ST_A;
                    end
                end
            end

            ST_A:
            begin
                if (mul_done)
                begin
                    a_next     = AB_W'(mul_product);
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(s_high);
                    mul_mplier = MB_W'(n_low_reg);
                    state_next = ST_B;
                end
            end

            ST_B:
            begin
                // |D| squared
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(d_val);
                    mul_mplier = MB_W'(d_val);
                    state_next = ST_DSQ;
                end
            end

            ST_DSQ:
            begin
                if (mul_done)
                begin
                    dsq_next   = DSQ_W'(mul_product);
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(n_low_reg);
                    mul_mplier = MB_W'(n_high);
                    state_next = ST_DEN;
                end
            end

            ST_DEN:
            begin
                if (mul_done)
                begin
                    den_next   = DEN_W'(mul_product);
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(dsq_reg);
                    mul_mplier = MB_W'(best_den_reg);
                    state_next = ST_LEFT;
                end
            end

            ST_LEFT:
            begin
                if (mul_done)
                begin
                    left_next  = mul_product;
                    mul_start  = 1'b1;
                    mul_mcand  = PROD_W'(best_dsq_reg);
                    mul_mplier = MB_W'(den_reg);
                    state_next = ST_RIGHT;
                end
            end

            ST_RIGHT:
            begin
                // strictly better only, so the lowest split wins ties
                if (mul_done)
                begin
                    if (left_reg > mul_product)
                    begin
                        best_dsq_next = dsq_reg;
                        best_den_next = den_reg;
                        best_t_next   = THR_W'(t_reg);
                    end
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                if (t_reg == HIST_AW'(MAX_COVERAGE))
                begin
                    hist_req.clear = 1'b1;
                    cell_cnt_next  = '0;
                    s_total_next   = '0;
                    n_low_next     = '0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    t_next     = t_reg + HIST_AW'(1);
                    state_next = ST_READ;
                end
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cell_cnt_reg <= '0;
            s_total_reg  <= '0;
            n_low_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cell_cnt_reg <= cell_cnt_next;
            s_total_reg  <= s_total_next;
            n_low_reg    <= n_low_next;
        end
    end

    // Search datapath registers
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        s_low_reg    <= s_low_next;
        a_reg        <= a_next;
        dsq_reg      <= dsq_next;
        den_reg      <= den_next;
        left_reg     <= left_next;
        best_dsq_reg <= best_dsq_next;
        best_den_reg <= best_den_next;
        best_t_reg   <= best_t_next;
    end

`ifndef SYNTHESIS
    // No new cell is taken while a threshold waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("cell beat accepted while threshold pending");

    // Frame cap on counted cells
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_cnt_reg <= CNT_W'(MAX_CELLS))
        else $error("cell count above frame cap");

    // Low class never holds more cells than the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        n_low_reg <= cell_cnt_reg)
        else $error("low class count exceeds frame count");

    // Delivered threshold leaves an empty frame ready for loading
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && (cell_cnt_reg == '0) && (s_total_reg == '0))
        else $error("frame state not cleared after threshold beat");
`endif

endmodule
